FILE: sv/bct_pkg.sv
// Shared types and constants for the Bezier curve tessellator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bct_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_FRAC = 15;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 7;
  localparam int QDEPTH     = 2;
  localparam int DIV_BITS   = IDX_W + 17;

  // configuration register indexes
  localparam logic [7:0] REG_EXTENT_X = 8'd0;
  localparam logic [7:0] REG_EXTENT_Y = 8'd1;
  localparam logic [7:0] REG_CENTER_X = 8'd2;
  localparam logic [7:0] REG_CENTER_Y = 8'd3;

  localparam logic FUNC_QUAD  = 1'b0;
  localparam logic FUNC_CUBIC = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [15:0] p0_x;
    logic signed [15:0] p0_y;
    logic signed [15:0] p1_x;
    logic signed [15:0] p1_y;
    logic signed [15:0] p2_x;
    logic signed [15:0] p2_y;
    logic signed [15:0] p3_x;
    logic signed [15:0] p3_y;
    logic [CNT_W-1:0]   point_count;
  } bct_in_t;

  typedef struct packed {
    logic signed [19:0] out_x;
    logic signed [19:0] out_y;
    logic [IDX_W-1:0]   point_index;
    logic               last_point;
  } bct_out_t;

  // one curve job handed from the front to the back; pts[2*j+axis]
  typedef struct packed {
    logic              func;
    logic [7:0][15:0]  pts;
    logic [IDX_W-1:0]  last_idx;
  } bct_job_t;

  typedef struct packed {
    logic [15:0]        extent_x;
    logic [15:0]        extent_y;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
  } bct_cfg_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIV,
    BS_MUL,
    BS_EMIT
  } bct_state_t;

endpackage

`default_nettype wire

FILE: sv/bct_front.sv
// Front end: accepts curve requests, clamps the count and drops short curves.
// Depends on bct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bct_front import bct_pkg::*; (
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bct_in_t  in_data,
  input  wire logic     q_ready,
  output logic          q_push,
  output bct_job_t      q_job
);

  logic [CNT_W-1:0] n_sat;
  logic [CNT_W-1:0] n_need;
  logic             keep;

  always_comb begin
    n_sat  = (in_data.point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                        : in_data.point_count;
    n_need = (in_data.func == FUNC_CUBIC) ? CNT_W'(4) : CNT_W'(3);
    keep   = (n_sat >= n_need);
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && keep && rst_n;

  always_comb begin
    q_job.func     = in_data.func;
    q_job.pts      = {in_data.p3_y, in_data.p3_x, in_data.p2_y, in_data.p2_x,
                      in_data.p1_y, in_data.p1_x, in_data.p0_y, in_data.p0_x};
    q_job.last_idx = IDX_W'(n_sat - CNT_W'(1));
  end

endmodule

`default_nettype wire

FILE: sv/bct_queue.sv
// Short job queue between front and back end.
// Depends on bct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bct_queue import bct_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire bct_job_t  push_job,
  output logic           push_ready,
  output logic           pop_valid,
  output bct_job_t       pop_job,
  input  wire logic      pop
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  bct_job_t          mem [QDEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]       count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (PW+1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bct_back.sv
// Back end: per-point t division, Bernstein weights, weighted sums, scaling.
// One shared 35x18 multiplier; depends on bct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bct_back import bct_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire bct_cfg_t  cfg,
  input  wire logic      q_valid,
  input  wire bct_job_t  q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output bct_out_t       out_data
);

  // micro-steps of the multiply phase
  localparam logic [4:0] S_UU    = 5'd0;
  localparam logic [4:0] S_UT    = 5'd1;
  localparam logic [4:0] S_TT    = 5'd2;
  localparam logic [4:0] S_W0    = 5'd3;
  localparam logic [4:0] S_W1    = 5'd4;
  localparam logic [4:0] S_W2    = 5'd5;
  localparam logic [4:0] S_W3    = 5'd6;
  localparam logic [4:0] S_ACC_X = 5'd7;
  localparam logic [4:0] S_ACC_Y = 5'd15;
  localparam logic [4:0] S_SX    = 5'd23;
  localparam logic [4:0] S_SY    = 5'd24;
  localparam logic [4:0] S_END   = 5'd25;

  localparam logic [16:0]        T_ONE  = 17'h10000;
  localparam logic signed [17:0] B_ONE  = 18'sh10000;
  localparam int                 BW     = $clog2(DIV_BITS);
  localparam logic signed [64:0] BIAS   = 65'sd1 <<< 47;
  localparam logic signed [52:0] RND    = 53'sd1 <<< (COORD_FRAC-1);

  bct_state_t st_r, st_nxt;

  logic               func_r;
  logic [7:0][15:0]   pts_r;
  logic [IDX_W-1:0]   last_r;
  logic [IDX_W-1:0]   i_r;
  logic [DIV_BITS-1:0] num_r;
  logic [6:0]         rem_r;
  logic [16:0]        quo_r;
  logic [BW-1:0]      bit_r;
  logic [16:0]        t_r, u_r;
  logic [4:0]         step_r;
  logic signed [52:0] prod_r;
  logic [32:0]        u2_r, ut_r, t2_r;
  logic [48:0]        w_r [4];
  logic signed [64:0] acc_x_r, acc_y_r;
  logic signed [19:0] vx_r, vy_r;
  bct_out_t           out_r;
  logic               out_valid_r, out_valid_nxt;

  logic div_done, mul_done, emit;

  // ---------------- control ----------------
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BS_IDLE: if (q_valid)  st_nxt = BS_DIV;
      BS_DIV:  if (div_done) st_nxt = BS_MUL;
      BS_MUL:  if (mul_done) st_nxt = BS_EMIT;
      BS_EMIT: if (emit)     st_nxt = (i_r == last_r) ? BS_IDLE : BS_DIV;
      default:               st_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (st_r == BS_IDLE) && q_valid;
    div_done = (st_r == BS_DIV) && (bit_r == BW'(DIV_BITS-1));
    mul_done = (st_r == BS_MUL) && (step_r == S_END);
    emit     = (st_r == BS_EMIT) && (!out_valid_r || out_ready);
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (emit)                     out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- restoring divider for t ----------------
  logic [7:0] rem_sh;
  logic [6:0] dvs;
  logic       ge;
  logic [16:0] quo_nxt;

  always_comb begin
    dvs     = {last_r, 1'b0};
    rem_sh  = {rem_r, num_r[DIV_BITS-1]};
    ge      = (rem_sh >= {1'b0, dvs});
    quo_nxt = {quo_r[15:0], ge};
  end

  // ---------------- shared multiplier ----------------
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic [2:0]         arel;
  logic               aaxis;
  logic [48:0]        wsel;

  always_comb begin
    aaxis = (step_r >= S_ACC_Y);
    arel  = aaxis ? 3'(step_r - S_ACC_Y) : 3'(step_r - S_ACC_X);
    wsel  = w_r[arel[2:1]];
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      S_UU: begin mul_a = $signed({18'b0, u_r}); mul_b = $signed({1'b0, u_r}); end
      S_UT: begin mul_a = $signed({18'b0, u_r}); mul_b = $signed({1'b0, t_r}); end
      S_TT: begin mul_a = $signed({18'b0, t_r}); mul_b = $signed({1'b0, t_r}); end
      S_W0: begin
        mul_a = $signed({2'b0, u2_r});
        mul_b = func_r ? $signed({1'b0, u_r}) : B_ONE;
      end
      S_W1: begin
        mul_a = func_r ? $signed({2'b0, u2_r}) : $signed({2'b0, ut_r});
        mul_b = func_r ? $signed({1'b0, t_r}) : B_ONE;
      end
      S_W2: begin
        mul_a = $signed({2'b0, t2_r});
        mul_b = func_r ? $signed({1'b0, u_r}) : B_ONE;
      end
      S_W3: begin
        mul_a = $signed({2'b0, t2_r});
        mul_b = func_r ? $signed({1'b0, t_r}) : '0;
      end
      S_SX: begin
        mul_a = 35'($signed(acc_x_r[64:48]));
        mul_b = $signed({2'b0, cfg.extent_x});
      end
      S_SY: begin
        mul_a = 35'($signed(acc_y_r[64:48]));
        mul_b = $signed({2'b0, cfg.extent_y});
      end
      default: begin
        if (step_r >= S_ACC_X && step_r < S_SX) begin
          mul_a = arel[0] ? $signed({11'b0, wsel[23:0]}) : $signed({10'b0, wsel[48:24]});
          mul_b = 18'($signed(pts_r[{arel[2:1], aaxis}]));
        end
      end
    endcase
  end

  // ---------------- consume previous product ----------------
  logic [4:0]         pstep;
  logic [2:0]         prel;
  logic               paxis;
  logic [48:0]        pw;
  logic [48:0]        pw3;
  logic signed [64:0] term;

  always_comb begin
    pstep = step_r - 5'd1;
    paxis = (pstep >= S_ACC_Y);
    prel  = paxis ? 3'(pstep - S_ACC_Y) : 3'(pstep - S_ACC_X);
    pw    = prod_r[48:0];
    pw3   = pw + {pw[47:0], 1'b0};
    term  = prel[0] ? 65'(prod_r) : (65'(prod_r) <<< 24);
  end

  function automatic logic signed [19:0] scale_sat(input logic signed [52:0] p,
                                                   input logic signed [15:0] c);
    logic signed [52:0] rnd;
    logic signed [23:0] sc;
    logic signed [23:0] v;
    rnd = p + RND;
    sc  = 24'(rnd >>> COORD_FRAC);
    v   = sc + 24'(c);
    if (v > 24'sd524287)       scale_sat = 20'sd524287;
    else if (v < -24'sd524288) scale_sat = -20'sd524288;
    else                       scale_sat = v[19:0];
  endfunction

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (q_pop) begin
      func_r <= q_job.func;
      pts_r  <= q_job.pts;
      last_r <= q_job.last_idx;
      i_r    <= '0;
      num_r  <= DIV_BITS'(q_job.last_idx);
      rem_r  <= '0;
      quo_r  <= '0;
      bit_r  <= '0;
    end
    if (st_r == BS_DIV) begin
      rem_r  <= ge ? 7'(rem_sh - {1'b0, dvs}) : rem_sh[6:0];
      quo_r  <= quo_nxt;
      num_r  <= {num_r[DIV_BITS-2:0], 1'b0};
      bit_r  <= bit_r + BW'(1);
      if (div_done) begin
        t_r    <= quo_nxt;
        u_r    <= T_ONE - quo_nxt;
        step_r <= S_UU;
      end
    end
    if (st_r == BS_MUL) begin
      prod_r <= mul_a * mul_b;
      step_r <= step_r + 5'd1;
      if (step_r != S_UU) begin
        case (pstep)
          S_UU: u2_r   <= prod_r[32:0];
          S_UT: ut_r   <= prod_r[32:0];
          S_TT: t2_r   <= prod_r[32:0];
          S_W0: w_r[0] <= pw;
          S_W1: w_r[1] <= func_r ? pw3 : {pw[47:0], 1'b0};
          S_W2: w_r[2] <= func_r ? pw3 : pw;
          S_W3: w_r[3] <= pw;
          S_SX: vx_r   <= scale_sat(prod_r, cfg.center_x);
          S_SY: vy_r   <= scale_sat(prod_r, cfg.center_y);
          default: begin
            if (pstep >= S_ACC_X && pstep < S_SX) begin
              if (paxis) begin
                acc_y_r <= (pstep == S_ACC_Y) ? term + BIAS : acc_y_r + term;
              end else begin
                acc_x_r <= (pstep == S_ACC_X) ? term + BIAS : acc_x_r + term;
              end
            end
          end
        endcase
      end
    end
    if (emit) begin
      out_r.out_x       <= vx_r;
      out_r.out_y       <= vy_r;
      out_r.point_index <= i_r;
      out_r.last_point  <= (i_r == last_r);
      i_r               <= i_r + IDX_W'(1);
      num_r             <= {i_r + IDX_W'(1), 17'b0} + DIV_BITS'(last_r);
      rem_r             <= '0;
      quo_r             <= '0;
      bit_r             <= '0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bezier_curve_tessellator.sv
// Bezier curve tessellator: each point of a curve takes a 23-step t division,
// 26 steps on the shared multiplier and a hand-off to the output register; the
// back end evaluates the points of a curve in turn and pops the next curve after the last.
// A two-word job queue lets new requests be taken while a curve is in progress.
// Reset (rst_n, synchronous, active low) empties the queue and output register and
// loads extent 16 (2^-11 with 15 fraction bits) and center 0; control points need no reset.
`timescale 1ns / 1ps
`default_nettype none

module bezier_curve_tessellator import bct_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // request words
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire bct_in_t      in_data,
  // point words
  output logic              out_valid,
  input  wire logic         out_ready,
  output bct_out_t          out_data,
  // register writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  bct_cfg_t cfg_r, cfg_nxt;

  // register file: writes to unknown indexes fall through
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_EXTENT_X: cfg_nxt.extent_x = cfg_data;
        REG_EXTENT_Y: cfg_nxt.extent_y = cfg_data;
        REG_CENTER_X: cfg_nxt.center_x = $signed(cfg_data);
        REG_CENTER_Y: cfg_nxt.center_y = $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.extent_x <= 16'd16;
      cfg_r.extent_y <= 16'd16;
      cfg_r.center_x <= '0;
      cfg_r.center_y <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // front: clamp count, drop curves too short to draw
  logic     q_push, q_ready, q_valid, q_pop;
  bct_job_t q_in_job, q_out_job;

  bct_front u_front (
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_job    (q_in_job)
  );

  bct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_in_job),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_job    (q_out_job),
    .pop        (q_pop)
  );

  // back: per-point evaluation with registered output word
  bct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_job     (q_out_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
